// ----- rtl/core/mexp_pkg.sv -----
// Package for the modular exponentiation block: operand widths, counter
// widths, configuration register indexes and the multiplier control struct.
// No dependencies.
package mexp_pkg;

    localparam int OP_W      = 31;
    localparam int CNT_W     = $clog2(OP_W);
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b1;

    typedef logic [OP_W-1:0] t_operand;

    typedef struct packed {
        logic load;
        logic step;
    } t_mm_ctrl;

endpackage

// ----- rtl/core/mexp_if.sv -----
// Valid/ready channel interfaces for the modular exponentiation block:
// message input, result output and configuration write.
// Depends on mexp_pkg.
interface mexp_msg_if;
    logic               valid;
    logic               ready;
    mexp_pkg::t_operand message;

    modport source (output valid, output message, input ready);
    modport sink   (input valid, input message, output ready);
endinterface

interface mexp_res_if;
    logic               valid;
    logic               ready;
    mexp_pkg::t_operand power_mod;

    modport source (output valid, output power_mod, input ready);
    modport sink   (input valid, input power_mod, output ready);
endinterface

interface mexp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mexp_pkg::CFG_IDX_W-1:0] index;
    mexp_pkg::t_operand             data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/mexp_mulmod.sv -----
// Bit-serial modular multiplier: (x * y) mod m, one bit of y per step,
// OP_W steps after a load. Operands must already be below the modulus.
// Depends on mexp_pkg.
module mexp_mulmod (
    input  logic               i_clk,
    input  mexp_pkg::t_mm_ctrl i_ctrl,
    input  mexp_pkg::t_operand i_x,
    input  mexp_pkg::t_operand i_y,
    input  mexp_pkg::t_operand i_mod,
    output mexp_pkg::t_operand o_prod
);

    mexp_pkg::t_operand r_x;
    mexp_pkg::t_operand r_y;
    mexp_pkg::t_operand r_p;
    mexp_pkg::t_operand n_x;
    mexp_pkg::t_operand n_p;

    logic [mexp_pkg::OP_W:0] w_sum;
    logic [mexp_pkg::OP_W:0] w_dbl;
    logic [mexp_pkg::OP_W:0] w_mod;

    always_comb begin
        w_mod = {1'b0, i_mod};
        w_sum = {1'b0, r_p} + {1'b0, r_x};
        w_dbl = {r_x, 1'b0};
        n_p   = r_p;
        if (r_y[0]) begin
            n_p = (w_sum >= w_mod) ? mexp_pkg::OP_W'(w_sum - w_mod)
                                   : w_sum[mexp_pkg::OP_W-1:0];
        end
        n_x = (w_dbl >= w_mod) ? mexp_pkg::OP_W'(w_dbl - w_mod)
                               : w_dbl[mexp_pkg::OP_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_x <= i_x;
            r_y <= i_y;
            r_p <= '0;
        end else if (i_ctrl.step) begin
            r_x <= n_x;
            r_y <= {1'b0, r_y[mexp_pkg::OP_W-1:1]};
            r_p <= n_p;
        end
    end

    assign o_prod = r_p;

endmodule

// ----- rtl/core/modular_exponentiation.sv -----
// Top level of the modular exponentiation block (right-to-left square and
// multiply). Depends on mexp_pkg, the channel interfaces and mexp_mulmod.
//
// Usage:
//   i_cfg writes the modulus (index 0, reset 2) and the exponent (index 1,
//   reset 0); it is always ready. The user must write it only while the
//   block is idle; the block does not enforce it. i_msg takes one message item;
//   o_res returns message^exponent mod modulus (1 for exponent 0, 0 for modulus 0).
// Sequence: the message is reduced one bit a cycle, then for each of the
//   OP_W exponent bits come one load, OP_W multiply steps and one update,
//   then the result is registered. The multiply and the squaring run in two
//   bit-serial multipliers side by side, driven by one shared load/step control.
// Throughput: one item at a time; the next item is taken as soon as the
//   block is back in idle, even while the previous result still waits.
// Reset: clears the control state and loads the register reset values.
// Stall: a finished result waits in the working registers until the output
//   register is free.
module modular_exponentiation (
    input  logic i_clk,
    input  logic i_rst_n,
    mexp_cfg_if.sink   i_cfg,
    mexp_msg_if.sink   i_msg,
    mexp_res_if.source o_res
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REDUCE = 3'd1;
    localparam logic [2:0] S_LOAD   = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_NEXT   = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    localparam logic [mexp_pkg::CNT_W-1:0] CNT_LAST = mexp_pkg::CNT_W'(mexp_pkg::OP_W - 1);

    logic [2:0]                    r_state;
    logic [mexp_pkg::CNT_W-1:0]    r_cnt;
    logic [mexp_pkg::CNT_W-1:0]    r_ebit;
    mexp_pkg::t_operand            r_mod;
    mexp_pkg::t_operand            r_exp_cfg;
    mexp_pkg::t_operand            r_exp;
    mexp_pkg::t_operand            r_msg;
    mexp_pkg::t_operand            r_base;
    mexp_pkg::t_operand            r_acc;
    mexp_pkg::t_operand            r_out;
    logic                          r_out_valid;

    logic [mexp_pkg::OP_W:0]       w_shl;
    mexp_pkg::t_operand            n_red;
    mexp_pkg::t_operand            n_out;
    mexp_pkg::t_operand            w_mul_prod;
    mexp_pkg::t_operand            w_sqr_prod;
    mexp_pkg::t_mm_ctrl            w_ctrl;
    logic                          w_out_free;

    assign i_cfg.ready = 1'b1;
    assign i_msg.ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.power_mod = r_out;

    assign w_ctrl.load = (r_state == S_LOAD);
    assign w_ctrl.step = (r_state == S_MUL);
    assign w_out_free  = !r_out_valid || o_res.ready;

    // message mod modulus, one bit a cycle, MSB first
    always_comb begin
        w_shl = {r_base, r_msg[mexp_pkg::OP_W-1]};
        n_red = (w_shl >= {1'b0, r_mod}) ? mexp_pkg::OP_W'(w_shl - {1'b0, r_mod})
                                         : w_shl[mexp_pkg::OP_W-1:0];
    end

    always_comb begin
        if (r_mod == '0) begin
            n_out = '0;
        end else if (r_exp_cfg == '0) begin
            n_out = mexp_pkg::OP_W'(1);
        end else begin
            n_out = r_acc;
        end
    end

    mexp_mulmod u_mul (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_x    (r_acc),
        .i_y    (r_base),
        .i_mod  (r_mod),
        .o_prod (w_mul_prod)
    );

    mexp_mulmod u_sqr (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_x    (r_base),
        .i_y    (r_base),
        .i_mod  (r_mod),
        .o_prod (w_sqr_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod     <= mexp_pkg::OP_W'(2);
            r_exp_cfg <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                mexp_pkg::REG_MODULUS:  r_mod     <= i_cfg.data;
                mexp_pkg::REG_EXPONENT: r_exp_cfg <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FINISH) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_ebit      <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_msg.valid) begin
                        r_msg   <= i_msg.message;
                        r_base  <= '0;
                        r_exp   <= r_exp_cfg;
                        r_acc   <= (r_mod == mexp_pkg::OP_W'(1)) ? '0 : mexp_pkg::OP_W'(1);
                        r_cnt   <= '0;
                        r_ebit  <= '0;
                        r_state <= S_REDUCE;
                    end
                end
                S_REDUCE: begin
                    r_base <= n_red;
                    r_msg  <= {r_msg[mexp_pkg::OP_W-2:0], 1'b0};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_exp[0]) begin
                        r_acc <= w_mul_prod;
                    end
                    r_base <= w_sqr_prod;
                    r_exp  <= {1'b0, r_exp[mexp_pkg::OP_W-1:1]};
                    r_ebit <= r_ebit + 1'b1;
                    r_state <= (r_ebit == CNT_LAST) ? S_FINISH : S_LOAD;
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out       <= n_out;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
